[rtl/hvpm_pkg.sv]
// Package: shared types and constants of the hydraulic valve and pump mixer.
package hvpm_pkg;

  // Pulse widths in microseconds.
  localparam logic [11:0] CenterUs     = 12'd1500;
  localparam logic [11:0] SwitchLowUs  = 12'd1450;
  localparam logic [11:0] SwitchHighUs = 12'd1550;
  localparam logic [12:0] RampFloorUs  = 13'd1550;

  // Switch band codes.
  localparam logic [1:0] SwPosLow  = 2'd0;
  localparam logic [1:0] SwPosMid  = 2'd1;
  localparam logic [1:0] SwPosHigh = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] RegBucketTrim  = 3'd0;
  localparam logic [2:0] RegBoomTrim    = 3'd1;
  localparam logic [2:0] RegStickTrim   = 3'd2;
  localparam logic [2:0] RegClosedBand  = 3'd3;
  localparam logic [2:0] RegOpenBand    = 3'd4;
  localparam logic [2:0] RegPumpMinDuty = 3'd5;
  localparam logic [2:0] RegPumpMaxDuty = 3'd6;
  localparam logic [2:0] RegRampLimit   = 3'd7;

  // Configuration register file contents.
  typedef struct packed {
    logic signed [7:0] bucket_trim;
    logic signed [7:0] boom_trim;
    logic signed [7:0] stick_trim;
    logic [9:0]        valve_closed_band;
    logic [9:0]        valve_open_band;
    logic [9:0]        pump_min_duty;
    logic [9:0]        pump_max_duty;
    logic [7:0]        ramp_limit;
  } cfg_t;

  // One input frame.
  typedef struct packed {
    logic [11:0] switch_pulse;
    logic [11:0] stick_pulse;
    logic [11:0] boom_pulse;
    logic [11:0] bucket_pulse;
  } frame_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  switch_position;
    logic        pump_active;
    logic [11:0] pump_pulse;
    logic [12:0] stick_valve_pulse;
    logic [12:0] boom_valve_pulse;
    logic [12:0] bucket_valve_pulse;
  } result_t;

endpackage

[rtl/hvpm_demand.sv]
// Per-channel pump demand: dead band, half-slope zone and full-slope zone.
module hvpm_demand
  import hvpm_pkg::*;
(
  input  logic [11:0] pulse_i,
  input  logic [9:0]  closed_band_i,
  input  logic [9:0]  open_band_i,
  output logic [11:0] demand_o
);

  logic [11:0] dev;
  logic [10:0] band_sum;
  logic [9:0]  band_mid;
  logic [11:0] half_zone;

  // Deviation from center.
  assign dev = (pulse_i < CenterUs) ? (CenterUs - pulse_i) : (pulse_i - CenterUs);

  // Midpoint of the two bands, truncated.
  assign band_sum  = {1'b0, closed_band_i} + {1'b0, open_band_i};
  assign band_mid  = band_sum[10:1];
  assign half_zone = dev - {2'b00, closed_band_i};

  // Zone selection; past both bands the deviation is above the midpoint.
  always_comb begin
    priority if (dev < {2'b00, closed_band_i}) begin
      demand_o = 12'd0;
    end else if (dev < {2'b00, open_band_i}) begin
      demand_o = {1'b0, half_zone[11:1]};
    end else begin
      demand_o = dev - {2'b00, band_mid};
    end
  end

endmodule

[rtl/hvpm_datapath.sv]
// Combinational mixer: valve trims, summed pump demand, ramp limit and switch bands.
module hvpm_datapath
  import hvpm_pkg::*;
(
  input  frame_t      frame_i,
  input  cfg_t        cfg_i,
  input  logic [11:0] prev_pump_i,
  output result_t     result_o
);

  logic [11:0] dem_bucket, dem_boom, dem_stick;
  logic [12:0] dem_sum;
  logic [13:0] duty_raw;
  logic [9:0]  duty;
  logic [11:0] pump_raw;
  logic [12:0] ramp_lim;
  logic [12:0] ramp_cap;
  logic        ramp_on;

  hvpm_demand u_dem_bucket (
    .pulse_i       (frame_i.bucket_pulse),
    .closed_band_i (cfg_i.valve_closed_band),
    .open_band_i   (cfg_i.valve_open_band),
    .demand_o      (dem_bucket)
  );

  hvpm_demand u_dem_boom (
    .pulse_i       (frame_i.boom_pulse),
    .closed_band_i (cfg_i.valve_closed_band),
    .open_band_i   (cfg_i.valve_open_band),
    .demand_o      (dem_boom)
  );

  hvpm_demand u_dem_stick (
    .pulse_i       (frame_i.stick_pulse),
    .closed_band_i (cfg_i.valve_closed_band),
    .open_band_i   (cfg_i.valve_open_band),
    .demand_o      (dem_stick)
  );

  // Valve pulse is the channel pulse plus trim, floored at zero.
  function automatic logic [12:0] valve_out(logic [11:0] pulse, logic signed [7:0] trim);
    logic signed [13:0] s;
    s = $signed({2'b00, pulse}) + 14'(trim);
    return s[13] ? 13'd0 : s[12:0];
  endfunction

  // Summed demand, minimum duty and maximum cap.
  assign dem_sum  = {1'b0, dem_bucket} + {1'b0, dem_boom} + {1'b0, dem_stick};
  assign duty_raw = {1'b0, dem_sum} + {4'd0, cfg_i.pump_min_duty};
  assign duty     = (duty_raw > {4'd0, cfg_i.pump_max_duty}) ? cfg_i.pump_max_duty
                                                             : duty_raw[9:0];
  assign pump_raw = (dem_sum == 13'd0) ? CenterUs : (CenterUs + {2'b00, duty});

  // Rise limit against the previous pulse, never below the floor.
  assign ramp_on  = (prev_pump_i != 12'd0) && (cfg_i.ramp_limit != 8'd0);
  assign ramp_lim = {1'b0, prev_pump_i} + {5'd0, cfg_i.ramp_limit};
  assign ramp_cap = (ramp_lim < RampFloorUs) ? RampFloorUs : ramp_lim;

  always_comb begin
    result_o.bucket_valve_pulse = valve_out(frame_i.bucket_pulse, cfg_i.bucket_trim);
    result_o.boom_valve_pulse   = valve_out(frame_i.boom_pulse, cfg_i.boom_trim);
    result_o.stick_valve_pulse  = valve_out(frame_i.stick_pulse, cfg_i.stick_trim);
    result_o.pump_active        = (dem_sum != 13'd0);

    // A capped value lies below the raw pulse, so it fits in 12 bits.
    if (ramp_on && ({1'b0, pump_raw} > ramp_cap)) begin
      result_o.pump_pulse = ramp_cap[11:0];
    end else begin
      result_o.pump_pulse = pump_raw;
    end

    priority if (frame_i.switch_pulse < SwitchLowUs) begin
      result_o.switch_position = SwPosLow;
    end else if (frame_i.switch_pulse > SwitchHighUs) begin
      result_o.switch_position = SwPosHigh;
    end else begin
      result_o.switch_position = SwPosMid;
    end
  end

endmodule

[rtl/hydraulic_valve_pump_mixer_core.sv]
// Top level of the hydraulic valve and pump mixer: registers, handshake and datapath.
//
// Each input beat is one radio frame; each produces exactly one result beat. The block
// takes one frame per clock while the output is not stalled: a frame is captured in
// an input register, mixed in combinational compare-add logic and written to the
// output register when that register is free. The result beat is held in the
// output register until the output side takes it. The input is held off only while both
// registers hold a frame and the output side is not ready. The pump ramp uses the
// previous pump pulse, held in one register updated as each result is formed, so
// consecutive frames follow each other without gaps. Configuration registers are
// written through a plain write port and must be changed only while no frame is in
// flight.
module hydraulic_valve_pump_mixer_core
  import hvpm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [9:0]  cfg_wdata_i,

  // Input frames.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata from bit 0: bucket_pulse[11:0], boom_pulse[23:12], stick_pulse[35:24],
  // switch_pulse[47:36]
  input  logic [47:0] s_axis_tdata,

  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata from bit 0: bucket_valve_pulse[12:0], boom_valve_pulse[25:13],
  // stick_valve_pulse[38:26], pump_pulse[50:39], pump_active[51],
  // switch_position[53:52], zero fill[55:54]
  output logic [55:0] m_axis_tdata
);

  cfg_t        cfg_q, cfg_d;
  frame_t      frame_q;
  logic        in_valid_q, in_valid_d;
  result_t     res_q, res_d;
  logic        out_valid_q, out_valid_d;
  logic [11:0] prev_pump_q;
  logic        out_ready;
  logic        advance;

  // Configuration register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegBucketTrim:  cfg_d.bucket_trim       = cfg_wdata_i[7:0];
        RegBoomTrim:    cfg_d.boom_trim         = cfg_wdata_i[7:0];
        RegStickTrim:   cfg_d.stick_trim        = cfg_wdata_i[7:0];
        RegClosedBand:  cfg_d.valve_closed_band = cfg_wdata_i;
        RegOpenBand:    cfg_d.valve_open_band   = cfg_wdata_i;
        RegPumpMinDuty: cfg_d.pump_min_duty     = cfg_wdata_i;
        RegPumpMaxDuty: cfg_d.pump_max_duty     = cfg_wdata_i;
        RegRampLimit:   cfg_d.ramp_limit        = cfg_wdata_i[7:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bucket_trim       <= -8'sd50;
      cfg_q.boom_trim         <= 8'sd50;
      cfg_q.stick_trim        <= -8'sd80;
      cfg_q.valve_closed_band <= 10'd220;
      cfg_q.valve_open_band   <= 10'd280;
      cfg_q.pump_min_duty     <= 10'd60;
      cfg_q.pump_max_duty     <= 10'd340;
      cfg_q.ramp_limit        <= 8'd20;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Pipeline flow: the output register frees when empty or taken.
  assign out_ready     = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_valid_d    = s_axis_tready ? s_axis_tvalid : in_valid_q;
  assign out_valid_d   = out_ready ? in_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      prev_pump_q <= 12'd0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        prev_pump_q <= res_d.pump_pulse;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      frame_q <= s_axis_tdata;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  hvpm_datapath u_datapath (
    .frame_i     (frame_q),
    .cfg_i       (cfg_q),
    .prev_pump_i (prev_pump_q),
    .result_o    (res_d)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, res_q};

  // The ramp state always matches the result on show.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (prev_pump_q == res_q.pump_pulse))
    else $error("ramp state differs from the pending pump pulse");

  // An idle pump always reads center.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.pump_active) |-> (res_q.pump_pulse == CenterUs))
    else $error("idle pump pulse is not center");

  // The pump pulse never drops below center.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.pump_pulse >= CenterUs))
    else $error("pump pulse below center");

  // Input is held off only when both registers are full and the output stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without cause");

endmodule
